### rtl/core/cit_pkg.sv
`timescale 1ns / 1ps

package cit_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int ID_W          = 32;
    localparam int SLOT_W        = 4;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [ID_W-1:0] EMPTY_ID = '0;

endpackage

### rtl/core/compacting_id_table.sv
`timescale 1ns / 1ps

// Packed table of nonzero 32-bit card IDs held in a single-port-write, single-port-read
// memory with a registered read; one sequencer walks it one slot per cycle. A request is
// taken when start is high and busy is low, and its result appears on the result ports
// for exactly one cycle with done high; the receiver cannot stall it, so capture it on
// that cycle. Insert and lookup scan the live slots until a match or the last live slot;
// delete of slot p moves the later entries down by one slot, and read of a live slot
// passes through the states S_RDA and S_RDB. done rises at the same edge at which busy
// falls, so the result is on the ports in the first cycle that busy is low. Requests
// refused at once (zero ID, slot not live) leave busy low and report on the next cycle.
// Slots beyond the live count read as empty without any clearing pass, so the table is
// usable right after reset.

module compacting_id_table #(
    parameter int TABLE_DEPTH = cit_pkg::DEFAULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cit_pkg::CMD_W-1:0]    command,
    input  logic [cit_pkg::ID_W-1:0]     card_id,
    input  logic [cit_pkg::SLOT_W-1:0]   slot,
    output logic                         done,
    output logic [cit_pkg::STATUS_W-1:0] status,
    output logic [cit_pkg::SLOT_W-1:0]   found_slot,
    output logic [cit_pkg::ENTRY_W-1:0]  entry_count,
    output logic [cit_pkg::ID_W-1:0]     read_id
);
    import cit_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_RDA   = 3'd3;
    localparam logic [2:0] S_RDB   = 3'd4;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    logic [2:0]          state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       pend_idx_reg, pend_idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   found_reg, found_next;
    logic [ID_W-1:0]     read_id_reg, read_id_next;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;
    logic [ID_W-1:0] rd_data;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic            pos_live;
    logic            accept;
    logic            hit;
    logic            more;

    cit_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign pos_ext  = PW'(slot);
    assign cnt_ext  = PW'(count_reg);
    assign pos_live = pos_ext < cnt_ext;
    assign hit      = pend_reg && (rd_data == id_reg);
    assign more     = idx_reg < count_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        read_id_next  = read_id_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data       = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = command;
                    id_next      = card_id;
                    pend_next    = 1'b0;
                    status_next  = ST_OK;
                    found_next   = '0;
                    read_id_next = EMPTY_ID;
                    case (command)
                        CMD_INSERT, CMD_LOOKUP:
                        begin
                            idx_next = '0;
                            if (card_id == EMPTY_ID)
                            begin
                                done_next   = 1'b1;
                                status_next = (command == CMD_INSERT) ? ST_PRESENT : ST_ABSENT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DELETE:
                        begin
                            idx_next = CW'(pos_ext[CW-1:0] + 1'b1);
                            if (pos_live)
                            begin
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            idx_next = pos_ext[CW-1:0];
                            if (pos_live)
                            begin
                                state_next = S_RDA;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    done_next   = 1'b1;
                    status_next = (cmd_reg == CMD_INSERT) ? ST_PRESENT : ST_OK;
                    found_next  = SLOT_W'(pend_idx_reg);
                    pend_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                    idx_next      = CW'(idx_reg + 1'b1);
                end
                else
                begin
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // append at the first free slot
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[IW-1:0];
                        wr_data     = id_reg;
                        found_next  = SLOT_W'(count_reg);
                        count_next  = CW'(count_reg + 1'b1);
                        status_next = ST_OK;
                    end
                end
            end

            S_SHIFT:
            begin
                // move the entry read last cycle down by one slot
                wr_en = pend_reg;
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = IW'(idx_reg - 1'b1);
                    idx_next      = CW'(idx_reg + 1'b1);
                end
                else
                begin
                    pend_next   = 1'b0;
                    count_next  = CW'(count_reg - 1'b1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end

            S_RDA:
            begin
                state_next = S_RDB;
            end

            S_RDB:
            begin
                done_next    = 1'b1;
                read_id_next = rd_data;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        read_id_reg  <= read_id_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_slot  = found_reg;
    assign entry_count = ENTRY_W'(count_reg);
    assign read_id     = read_id_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("live count beyond table depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((command == CMD_DELETE) || (command == CMD_READ)) && pos_live)
        |=> busy)
        else $error("live slot request did not start the sequencer");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL)) |-> (count_reg == FULL_COUNT))
        else $error("full reported with free slots");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (cmd_reg == CMD_INSERT) && (status_reg == ST_OK))
        |-> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("insert did not grow the table by one");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("memory write while idle");

endmodule

### rtl/core/cit_store.sv
`timescale 1ns / 1ps

module cit_store #(
    parameter int DEPTH  = cit_pkg::DEFAULT_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [cit_pkg::ID_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [cit_pkg::ID_W-1:0] rd_data
);
    import cit_pkg::*;

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
